// ===== design/u16u8_pkg.sv =====
`default_nettype none
package u16u8_pkg;

	localparam logic [1:0] MODE_UNDECIDED = 2'd0;
	localparam logic [1:0] MODE_PASS      = 2'd1;
	localparam logic [1:0] MODE_LITTLE    = 2'd2;
	localparam logic [1:0] MODE_BIG       = 2'd3;

	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [7:0] BOM_FE = 8'hFE;

	// top six bits of a high and a low surrogate
	localparam logic [5:0] HIGH_TAG = 6'b110110;
	localparam logic [5:0] LOW_TAG  = 6'b110111;

	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [20:0] LIM_1B    = 21'h80;
	localparam logic [20:0] LIM_2B    = 21'h800;
	localparam logic [20:0] LIM_3B    = 21'h10000;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	// one thing to emit: a raw byte or a code point
	typedef struct packed {
		logic        raw;
		logic [20:0] cp;
	} ent_t;

	// work for one input beat: one or two entries
	typedef struct packed {
		logic two;
		ent_t e0;
		ent_t e1;
	} job_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== design/u16u8_front.sv =====
`default_nettype none
module u16u8_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            stream_last,
	input  wire logic            q_full,
	output logic                 push,
	output u16u8_pkg::job_t      job
);
	import u16u8_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic        first_q, first_d;
	logic [7:0]  held_q, held_d;
	logic        half_q, half_d;
	logic [9:0]  phb_q, phb_d;
	logic        phv_q, phv_d;
	logic [15:0] unit;
	logic [1:0]  n;
	ent_t        e0, e1;
	logic        acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		mode_d  = mode_q;
		first_d = first_q;
		held_d  = held_q;
		half_d  = half_q;
		phb_d   = phb_q;
		phv_d   = phv_q;
		n       = 2'd0;
		e0      = '0;
		e1      = '0;
		unit    = (mode_q == MODE_LITTLE) ? {in_byte, held_q} : {held_q, in_byte};
		case (mode_q)
			MODE_UNDECIDED: begin
				if (!first_q) begin
					if (stream_last) begin
						e0 = '{raw: 1'b1, cp: {13'd0, in_byte}};
						n  = 2'd1;
					end else begin
						held_d  = in_byte;
						first_d = 1'b1;
					end
				end else begin
					if (held_q == BOM_FF && in_byte == BOM_FE) begin
						mode_d = MODE_LITTLE;
					end else if (held_q == BOM_FE && in_byte == BOM_FF) begin
						mode_d = MODE_BIG;
					end else begin
						mode_d = MODE_PASS;
						e0 = '{raw: 1'b1, cp: {13'd0, held_q}};
						e1 = '{raw: 1'b1, cp: {13'd0, in_byte}};
						n  = 2'd2;
					end
					first_d = 1'b0;
					held_d  = '0;
				end
			end
			MODE_PASS: begin
				e0 = '{raw: 1'b1, cp: {13'd0, in_byte}};
				n  = 2'd1;
			end
			default: begin
				if (!half_q) begin
					held_d = in_byte;
					half_d = 1'b1;
				end else begin
					half_d = 1'b0;
					held_d = '0;
					if (phv_q && unit[15:10] == LOW_TAG) begin
						e0    = '{raw: 1'b0, cp: 21'({phb_q, unit[9:0]}) + SUPP_BASE};
						n     = 2'd1;
						phv_d = 1'b0;
						phb_d = '0;
					end else begin
						if (phv_q) begin
							e0    = '{raw: 1'b0, cp: {5'd0, HIGH_TAG, phb_q}};
							n     = 2'd1;
							phv_d = 1'b0;
							phb_d = '0;
						end
						if (unit[15:10] == HIGH_TAG) begin
							phb_d = unit[9:0];
							phv_d = 1'b1;
						end else begin
							if (n == 2'd0) begin
								e0 = '{raw: 1'b0, cp: {5'd0, unit}};
							end else begin
								e1 = '{raw: 1'b0, cp: {5'd0, unit}};
							end
							n = n + 2'd1;
						end
					end
				end
			end
		endcase
		if (stream_last) begin
			if (phv_d) begin
				if (n == 2'd0) begin
					e0 = '{raw: 1'b0, cp: {5'd0, HIGH_TAG, phb_d}};
				end else begin
					e1 = '{raw: 1'b0, cp: {5'd0, HIGH_TAG, phb_d}};
				end
				n = n + 2'd1;
			end
			mode_d  = MODE_UNDECIDED;
			first_d = 1'b0;
			held_d  = '0;
			half_d  = 1'b0;
			phb_d   = '0;
			phv_d   = 1'b0;
		end
	end

	assign push = acc && (n != 2'd0);
	assign job  = '{two: n[1], e0: e0, e1: e1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UNDECIDED;
			first_q <= 1'b0;
			held_q  <= '0;
			half_q  <= 1'b0;
			phb_q   <= '0;
			phv_q   <= 1'b0;
		end else if (acc) begin
			mode_q  <= mode_d;
			first_q <= first_d;
			held_q  <= held_d;
			half_q  <= half_d;
			phb_q   <= phb_d;
			phv_q   <= phv_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/u16u8_queue.sv =====
`default_nettype none
module u16u8_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u16u8_pkg::job_t  wr_job,
	input  wire logic             pop,
	output u16u8_pkg::job_t       rd_job,
	output u16u8_pkg::q_stat_t    stat
);
	import u16u8_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/u16u8_back.sv =====
`default_nettype none
module u16u8_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire u16u8_pkg::job_t  q_job,
	input  wire logic             q_valid,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_last
);
	import u16u8_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic       sel_q;
	logic [1:0] idx_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;

	ent_t       ent;
	logic [1:0] len_m1;
	logic [7:0] cur_byte;
	logic       ent_end, job_end, adv;

	assign ent = sel_q ? job_q.e1 : job_q.e0;

	always_comb begin
		if (ent.raw || ent.cp < LIM_1B) begin
			len_m1 = 2'd0;
		end else if (ent.cp < LIM_2B) begin
			len_m1 = 2'd1;
		end else if (ent.cp < LIM_3B) begin
			len_m1 = 2'd2;
		end else begin
			len_m1 = 2'd3;
		end
	end

	always_comb begin
		cur_byte = CONT_B | {2'b00, ent.cp[5:0]};
		case (len_m1)
			2'd0: cur_byte = ent.cp[7:0];
			2'd1: begin
				if (idx_q == 2'd0) begin
					cur_byte = LEAD_2B | {3'b000, ent.cp[10:6]};
				end
			end
			2'd2: begin
				case (idx_q)
					2'd0:    cur_byte = LEAD_3B | {4'b0000, ent.cp[15:12]};
					2'd1:    cur_byte = CONT_B | {2'b00, ent.cp[11:6]};
					default: cur_byte = CONT_B | {2'b00, ent.cp[5:0]};
				endcase
			end
			default: begin
				case (idx_q)
					2'd0:    cur_byte = LEAD_4B | {5'b00000, ent.cp[20:18]};
					2'd1:    cur_byte = CONT_B | {2'b00, ent.cp[17:12]};
					2'd2:    cur_byte = CONT_B | {2'b00, ent.cp[11:6]};
					default: cur_byte = CONT_B | {2'b00, ent.cp[5:0]};
				endcase
			end
		endcase
	end

	assign ent_end = (idx_q == len_m1);
	assign job_end = ent_end && (sel_q || !job_q.two);
	assign adv     = !ov_q || out_ready;
	assign q_pop   = q_valid && (!busy_q || (adv && job_end));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (adv && busy_q) begin
			ob_q <= cur_byte;
			ol_q <= job_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				sel_q  <= 1'b0;
				idx_q  <= '0;
			end else if (adv && busy_q) begin
				if (job_end) begin
					busy_q <= 1'b0;
				end else if (ent_end) begin
					sel_q <= 1'b1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign run_last  = ol_q;

endmodule
`default_nettype wire

// ===== design/utf16_to_utf8_transcoder_unit.sv =====
// utf-16 to utf-8 transcoder for a marked byte stream. a leading ff fe or fe ff byte order
// mark selects little or big endian utf-16 and is dropped; otherwise bytes pass unchanged.
// surrogate pairs join into one code point, lone surrogates come out as three bytes, and an
// odd trailing byte is dropped. stream_last ends the stream and resets the state. the front
// stage takes one input beat per cycle while the queue has room; the back stage sends one
// output byte per cycle while out_ready is high, and one input beat may produce up to six
// output bytes. QUEUE_DEPTH sets how many input beats' worth of work may wait between the
// stages.
`default_nettype none
module utf16_to_utf8_transcoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       stream_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last
);
	import u16u8_pkg::*;

	logic    q_push, q_pop;
	job_t    wr_job, rd_job;
	q_stat_t q_stat;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.stream_last(stream_last),
		.q_full     (q_stat.full),
		.push       (q_push),
		.job        (wr_job)
	);

	u16u8_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_job(wr_job),
		.pop   (q_pop),
		.rd_job(rd_job),
		.stat  (q_stat)
	);

	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_job    (rd_job),
		.q_valid  (q_stat.valid),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	// work is queued only for an accepted beat
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (in_valid && in_ready))
		else $error("queue written without an accepted beat");

	// queued work does not vanish unless the back stage takes it
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.valid && !q_pop && !q_push) |=> q_stat.valid)
		else $error("queued work lost");

	// the queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("push into full queue");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import u16u8_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 150;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} utf8_beat_t;

	class utf8_byte_tracker;
		logic [1:0]  mode       = MODE_UNDECIDED;
		logic        first_seen = 1'b0;
		logic [7:0]  held       = 8'h00;
		logic        half_held  = 1'b0;
		logic [9:0]  high_bits  = 10'h000;
		logic        high_valid = 1'b0;
		utf8_beat_t  want_q[$];
		utf8_beat_t  step_q[$];
		int          beats_in   = 0;
		int          beats_out  = 0;
		int          errors     = 0;

		function void restart();
			mode       = MODE_UNDECIDED;
			first_seen = 1'b0;
			held       = 8'h00;
			half_held  = 1'b0;
			high_bits  = 10'h000;
			high_valid = 1'b0;
		endfunction

		function void put(logic [7:0] b);
			utf8_beat_t e;
			e.data = b;
			e.fin  = 1'b0;
			step_q = {step_q, e};
		endfunction

		function void encode_point(logic [20:0] cp);
			if (cp < LIM_1B) begin
				put(cp[7:0]);
			end else if (cp < LIM_2B) begin
				put(LEAD_2B | {3'b000, cp[10:6]});
				put(CONT_B | {2'b00, cp[5:0]});
			end else if (cp < LIM_3B) begin
				put(LEAD_3B | {4'b0000, cp[15:12]});
				put(CONT_B | {2'b00, cp[11:6]});
				put(CONT_B | {2'b00, cp[5:0]});
			end else begin
				put(LEAD_4B | {5'b00000, cp[20:18]});
				put(CONT_B | {2'b00, cp[17:12]});
				put(CONT_B | {2'b00, cp[11:6]});
				put(CONT_B | {2'b00, cp[5:0]});
			end
		endfunction

		function void flush_high();
			if (high_valid) begin
				encode_point({5'b00000, HIGH_TAG, high_bits});
				high_valid = 1'b0;
				high_bits  = 10'h000;
			end
		endfunction

		function void take_unit(logic [15:0] u);
			logic [20:0] cp;
			if (high_valid && u[15:10] == LOW_TAG) begin
				cp = SUPP_BASE + {1'b0, high_bits, u[9:0]};
				high_valid = 1'b0;
				high_bits  = 10'h000;
				encode_point(cp);
			end else begin
				flush_high();
				if (u[15:10] == HIGH_TAG) begin
					high_bits  = u[9:0];
					high_valid = 1'b1;
				end else begin
					encode_point({5'b00000, u});
				end
			end
		endfunction

		function void absorb_byte(logic [7:0] b, logic l);
			step_q.delete();
			beats_in++;
			case (mode)
				MODE_UNDECIDED: begin
					if (!first_seen) begin
						if (l) begin
							put(b);
						end else begin
							held       = b;
							first_seen = 1'b1;
						end
					end else begin
						if (held == BOM_FF && b == BOM_FE) begin
							mode = MODE_LITTLE;
						end else if (held == BOM_FE && b == BOM_FF) begin
							mode = MODE_BIG;
						end else begin
							mode = MODE_PASS;
							put(held);
							put(b);
						end
						first_seen = 1'b0;
						held       = 8'h00;
					end
				end
				MODE_PASS: begin
					put(b);
				end
				default: begin
					if (!half_held) begin
						held      = b;
						half_held = 1'b1;
					end else begin
						half_held = 1'b0;
						take_unit((mode == MODE_LITTLE) ? {b, held} : {held, b});
						held = 8'h00;
					end
				end
			endcase
			if (l) begin
				flush_high();
				restart();
			end
			if (step_q.size() > 0) begin
				step_q[step_q.size() - 1].fin = 1'b1;
			end
			want_q = {want_q, step_q};
		endfunction

		function void match_byte(logic [7:0] b, logic l);
			utf8_beat_t e;
			beats_out++;
			if (want_q.size() == 0) begin
				$error("unexpected output beat: out_byte %h run_last %b", b, l);
				errors++;
			end else begin
				e = want_q.pop_front();
				if (b !== e.data) begin
					$error("out_byte mismatch: expected %h, actual %h", e.data, b);
					errors++;
				end
				if (l !== e.fin) begin
					$error("run_last mismatch: expected %b, actual %b", e.fin, l);
					errors++;
				end
			end
		endfunction

		function int backlog();
			return want_q.size();
		endfunction
	endclass

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte     = 8'h00;
	logic       stream_last = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	utf8_byte_tracker board;
	int         send_gap_pct   = 0;
	int         recv_stall_pct = 0;
	int         phase_items    = 0;
	int         streams_sent   = 0;
	int         cycles         = 0;
	logic [7:0] stream_q[$];

	utf16_to_utf8_transcoder_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.stream_last(stream_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// input beat first, in case a result can leave in the cycle it arrives
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.absorb_byte(in_byte, stream_last);
			if (out_valid && out_ready) board.match_byte(out_byte, run_last);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL utf16_to_utf8_transcoder_unit");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		stream_last <= l;
		do @(posedge clk); while (!in_ready);
		phase_items++;
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
		streams_sent++;
	endtask

	task automatic drain_backlog();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.backlog() != 0);
	endtask

	task automatic add_byte(input logic [7:0] b);
		stream_q = {stream_q, b};
	endtask

	task automatic add_unit(input logic [15:0] u, input logic big);
		if (big) begin
			add_byte(u[15:8]);
			add_byte(u[7:0]);
		end else begin
			add_byte(u[7:0]);
			add_byte(u[15:8]);
		end
	endtask

	task automatic make_stream();
		logic [15:0] boundary_units[10] = '{16'h0000, 16'hFFFF, 16'hD7FF, 16'hE000, 16'hDBFF,
			16'hDFFF, 16'h007F, 16'h0080, 16'h07FF, 16'h0800};
		int          kind;
		int          n;
		logic        big;
		logic [15:0] u;
		stream_q.delete();
		kind = $urandom_range(9);
		if (kind == 0) begin
			n = $urandom_range(8, 1);
			repeat (n) add_byte(8'($urandom_range(255)));
		end else if (kind == 1) begin
			// near misses of a byte order mark
			add_byte($urandom_range(1) ? BOM_FF : BOM_FE);
			n = $urandom_range(5);
			repeat (n) add_byte(8'($urandom_range(255)));
		end else begin
			big = (kind > 5);
			add_byte(big ? BOM_FE : BOM_FF);
			add_byte(big ? BOM_FF : BOM_FE);
			n = $urandom_range(6);
			repeat (n) begin
				case ($urandom_range(9))
					0, 1: add_unit(16'($urandom_range(16'h007F)), big);
					2: add_unit(16'($urandom_range(16'h07FF, 16'h0080)), big);
					3: begin
						u = 16'($urandom_range(16'hFFFF, 16'h0800));
						if (u[15:11] == 5'b11011) u = u ^ 16'h2000;
						add_unit(u, big);
					end
					4, 5: begin
						add_unit(16'hD800 | 16'($urandom_range(16'h03FF)), big);
						add_unit(16'hDC00 | 16'($urandom_range(16'h03FF)), big);
					end
					6: add_unit(16'hD800 | 16'($urandom_range(16'h03FF)), big);
					7: add_unit(16'hDC00 | 16'($urandom_range(16'h03FF)), big);
					8: add_unit(16'($urandom_range(16'hFFFF)), big);
					default: add_unit(boundary_units[$urandom_range(9)], big);
				endcase
			end
			if ($urandom_range(4) == 0) add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int gap_pct, input int stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		phase_items    = 0;
		while (phase_items < RANDOM_ITEMS / 3) begin
			make_stream();
			send_stream();
		end
		drain_backlog();
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte stream, short pass stream
		stream_q = '{8'h41};
		send_stream();
		stream_q = '{8'hFF, 8'h00};
		send_stream();
		// little endian: ascii, ffff, pair, lone low, high then non-low
		stream_q = '{8'hFF, 8'hFE, 8'h41, 8'h00, 8'hFF, 8'hFF, 8'h3D, 8'hD8, 8'h00, 8'hDE,
			8'h00, 8'hDC, 8'h00, 8'hD8, 8'h80, 8'h00};
		send_stream();
		// big endian: top code point, then held high and odd byte at the end
		stream_q = '{8'hFE, 8'hFF, 8'hDB, 8'hFF, 8'hDF, 8'hFF, 8'hD8, 8'h00, 8'h12};
		send_stream();
		drain_backlog();

		run_phase(9, 66);
		run_phase(66, 9);
		run_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d input beats over %0d streams: pass, little and big endian,",
			board.beats_in, streams_sent);
		$display("surrogate pairs, lone surrogates, odd tails; %0d output beats checked",
			board.beats_out);
		if (board.errors == 0 && board.backlog() == 0) begin
			$display("PASS utf16_to_utf8_transcoder_unit");
		end else begin
			$display("FAIL utf16_to_utf8_transcoder_unit");
		end
		$finish;
	end

endmodule
